### hw/rtl/gpu_pkg.sv
// Shared types and constants for the geometric predicate unit.
// No dependencies; every other file of the unit imports this package.
package gpu_pkg;

  // Width of each coordinate field on the input channel
  localparam int FIELD_W = 16;

  // Register stages from input transfer to output register
  localparam int NSTG = 9;

  typedef enum logic [2:0] {
    CMD_XSIGN     = 3'd0,
    CMD_YSIGN     = 3'd1,
    CMD_XORDER    = 3'd2,
    CMD_YORDER    = 3'd3,
    CMD_NORMORDER = 3'd4,
    CMD_CCW       = 3'd5,
    CMD_LEFTTURN  = 3'd6,
    CMD_INCIRCLE  = 3'd7
  } cmd_t;

  localparam logic signed [1:0] SGN_ZERO = 2'sb00;
  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;

  // Load enables for the three front stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } front_en_t;

  // Load enables for the partial product and summation stages of a multiplier
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

endpackage

### hw/rtl/gpu_front.sv
// Front three stages: operand selection, squares and cross products, sums.
// Depends on gpu_pkg.
module gpu_front import gpu_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                       clk,
  input  front_en_t                  en,
  input  logic [2:0]                 command,
  input  logic signed [FIELD_W-1:0]  ax,
  input  logic signed [FIELD_W-1:0]  ay,
  input  logic signed [FIELD_W-1:0]  bx,
  input  logic signed [FIELD_W-1:0]  by,
  input  logic signed [FIELD_W-1:0]  cx,
  input  logic signed [FIELD_W-1:0]  cy,
  input  logic signed [FIELD_W-1:0]  px,
  input  logic signed [FIELD_W-1:0]  py,
  output logic signed [CW:0]         a1_o,
  output logic signed [CW:0]         a2_o,
  output logic signed [CW:0]         b1_o,
  output logic signed [CW:0]         b2_o,
  output logic signed [CW:0]         c1_o,
  output logic signed [CW:0]         c2_o,
  output logic signed [2*CW+2:0]     a3_o,
  output logic signed [2*CW+2:0]     b3_o,
  output logic signed [2*CW+2:0]     c3_o,
  output logic signed [2*CW+2:0]     cr_o,
  output logic signed [1:0]          early_sign_o,
  output logic                       inc_o
);

  localparam int DW   = CW + 1;
  localparam int SQW  = 2 * CW + 2;
  localparam int SUMW = 2 * CW + 3;

  // Low CW bits of the field, zero-filled above the field when CW is wider
  function automatic logic signed [CW-1:0] to_coord(input logic [FIELD_W-1:0] raw);
    logic [CW+FIELD_W-1:0] z;
    z = {{CW{1'b0}}, raw};
    return $signed(z[CW-1:0]);
  endfunction

  logic signed [CW-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c, px_c, py_c;
  cmd_t                 cmd_in;

  logic signed [DW-1:0] a1_nxt, a2_nxt, b1_nxt, b2_nxt, c1_nxt, c2_nxt;
  logic signed [DW-1:0] s1_a1_r, s1_a2_r, s1_b1_r, s1_b2_r, s1_c1_r, s1_c2_r;
  cmd_t                 s1_cmd_r;

  logic signed [SQW-1:0] sa1_r, sa2_r, sb1_r, sb2_r, sc1_r, sc2_r, m1_r, m2_r;
  logic signed [DW-1:0]  s2_a1_r, s2_a2_r, s2_b1_r, s2_b2_r, s2_c1_r, s2_c2_r;
  cmd_t                  s2_cmd_r;

  logic signed [SUMW-1:0] a3_nxt, b3_nxt, c3_nxt, cr_nxt;
  logic signed [SUMW:0]   nm_diff;
  logic signed [1:0]      es_nxt;

  logic signed [DW-1:0]   s3_a1_r, s3_a2_r, s3_b1_r, s3_b2_r, s3_c1_r, s3_c2_r;
  logic signed [SUMW-1:0] s3_a3_r, s3_b3_r, s3_c3_r, s3_cr_r;
  logic signed [1:0]      s3_es_r;
  logic                   s3_inc_r;

  // Stage 1: map every command onto the shared incircle datapath operands
  always_comb begin
    ax_c   = to_coord(ax);
    ay_c   = to_coord(ay);
    bx_c   = to_coord(bx);
    by_c   = to_coord(by);
    cx_c   = to_coord(cx);
    cy_c   = to_coord(cy);
    px_c   = to_coord(px);
    py_c   = to_coord(py);
    cmd_in = cmd_t'(command);
    a1_nxt = '0;
    a2_nxt = '0;
    b1_nxt = '0;
    b2_nxt = '0;
    c1_nxt = '0;
    c2_nxt = '0;
    case (cmd_in)
      CMD_XSIGN:  a1_nxt = DW'(ax_c);
      CMD_YSIGN:  a1_nxt = DW'(ay_c);
      CMD_XORDER: a1_nxt = DW'(bx_c) - DW'(ax_c);
      CMD_YORDER: a1_nxt = DW'(by_c) - DW'(ay_c);
      CMD_NORMORDER: begin
        a1_nxt = DW'(bx_c);
        a2_nxt = DW'(by_c);
        b1_nxt = DW'(ax_c);
        b2_nxt = DW'(ay_c);
      end
      CMD_CCW: begin
        b1_nxt = DW'(ax_c);
        c2_nxt = DW'(by_c);
        b2_nxt = DW'(ay_c);
        c1_nxt = DW'(bx_c);
      end
      CMD_LEFTTURN: begin
        b1_nxt = DW'(cx_c) - DW'(bx_c);
        c2_nxt = DW'(ay_c) - DW'(by_c);
        b2_nxt = DW'(cy_c) - DW'(by_c);
        c1_nxt = DW'(ax_c) - DW'(bx_c);
      end
      CMD_INCIRCLE: begin
        a1_nxt = DW'(ax_c) - DW'(px_c);
        a2_nxt = DW'(ay_c) - DW'(py_c);
        b1_nxt = DW'(bx_c) - DW'(px_c);
        b2_nxt = DW'(by_c) - DW'(py_c);
        c1_nxt = DW'(cx_c) - DW'(px_c);
        c2_nxt = DW'(cy_c) - DW'(py_c);
      end
      default: a1_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_a1_r  <= a1_nxt;
      s1_a2_r  <= a2_nxt;
      s1_b1_r  <= b1_nxt;
      s1_b2_r  <= b2_nxt;
      s1_c1_r  <= c1_nxt;
      s1_c2_r  <= c2_nxt;
      s1_cmd_r <= cmd_in;
    end
  end

  // Stage 2: squares and the two cross terms
  always_ff @(posedge clk) begin
    if (en.s2) begin
      sa1_r    <= SQW'(s1_a1_r) * SQW'(s1_a1_r);
      sa2_r    <= SQW'(s1_a2_r) * SQW'(s1_a2_r);
      sb1_r    <= SQW'(s1_b1_r) * SQW'(s1_b1_r);
      sb2_r    <= SQW'(s1_b2_r) * SQW'(s1_b2_r);
      sc1_r    <= SQW'(s1_c1_r) * SQW'(s1_c1_r);
      sc2_r    <= SQW'(s1_c2_r) * SQW'(s1_c2_r);
      m1_r     <= SQW'(s1_b1_r) * SQW'(s1_c2_r);
      m2_r     <= SQW'(s1_b2_r) * SQW'(s1_c1_r);
      s2_a1_r  <= s1_a1_r;
      s2_a2_r  <= s1_a2_r;
      s2_b1_r  <= s1_b1_r;
      s2_b2_r  <= s1_b2_r;
      s2_c1_r  <= s1_c1_r;
      s2_c2_r  <= s1_c2_r;
      s2_cmd_r <= s1_cmd_r;
    end
  end

  // Stage 3: lifted coordinates, 2x2 minor and the sign of the short commands
  always_comb begin
    a3_nxt  = SUMW'(sa1_r) + SUMW'(sa2_r);
    b3_nxt  = SUMW'(sb1_r) + SUMW'(sb2_r);
    c3_nxt  = SUMW'(sc1_r) + SUMW'(sc2_r);
    cr_nxt  = SUMW'(m1_r) - SUMW'(m2_r);
    nm_diff = (SUMW+1)'(a3_nxt) - (SUMW+1)'(b3_nxt);
    case (s2_cmd_r)
      CMD_XSIGN, CMD_YSIGN, CMD_XORDER, CMD_YORDER:
        es_nxt = s2_a1_r[DW-1] ? SGN_NEG : ((s2_a1_r != '0) ? SGN_POS : SGN_ZERO);
      CMD_NORMORDER:
        es_nxt = nm_diff[SUMW] ? SGN_NEG : ((nm_diff != '0) ? SGN_POS : SGN_ZERO);
      CMD_CCW, CMD_LEFTTURN:
        es_nxt = cr_nxt[SUMW-1] ? SGN_NEG : ((cr_nxt != '0) ? SGN_POS : SGN_ZERO);
      default:
        es_nxt = SGN_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_a1_r  <= s2_a1_r;
      s3_a2_r  <= s2_a2_r;
      s3_b1_r  <= s2_b1_r;
      s3_b2_r  <= s2_b2_r;
      s3_c1_r  <= s2_c1_r;
      s3_c2_r  <= s2_c2_r;
      s3_a3_r  <= a3_nxt;
      s3_b3_r  <= b3_nxt;
      s3_c3_r  <= c3_nxt;
      s3_cr_r  <= cr_nxt;
      s3_es_r  <= es_nxt;
      s3_inc_r <= (s2_cmd_r == CMD_INCIRCLE);
    end
  end

  assign a1_o         = s3_a1_r;
  assign a2_o         = s3_a2_r;
  assign b1_o         = s3_b1_r;
  assign b2_o         = s3_b2_r;
  assign c1_o         = s3_c1_r;
  assign c2_o         = s3_c2_r;
  assign a3_o         = s3_a3_r;
  assign b3_o         = s3_b3_r;
  assign c3_o         = s3_c3_r;
  assign cr_o         = s3_cr_r;
  assign early_sign_o = s3_es_r;
  assign inc_o        = s3_inc_r;

endmodule

### hw/rtl/gpu_mul.sv
// Two-stage signed multiplier: narrow operand times a wide operand cut into
// chunks of the narrow width; partial products, then shifted sum. Uses gpu_pkg.
module gpu_mul import gpu_pkg::*; #(
  parameter int AW = 17,
  parameter int BW = 35
) (
  input  logic                    clk,
  input  mul_en_t                 en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NC  = (BW + AW - 1) / AW;
  localparam int BXW = NC * AW;
  localparam int PPW = 2 * AW + 1;
  localparam int SW  = AW * (NC + 1) + 1;

  logic signed [BXW-1:0]   b_ext;
  logic signed [PPW-1:0]   pp_nxt [NC];
  logic signed [PPW-1:0]   pp_r   [NC];
  logic signed [SW-1:0]    acc;
  logic signed [AW+BW-1:0] p_r;

  // Low chunks are unsigned, the top chunk carries the sign
  always_comb begin
    b_ext = BXW'(b);
    for (int j = 0; j < NC; j++) begin
      if (j == NC - 1) begin
        pp_nxt[j] = PPW'(a) * PPW'($signed(b_ext[j*AW +: AW]));
      end else begin
        pp_nxt[j] = PPW'(a) * PPW'($signed({1'b0, b_ext[j*AW +: AW]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.pp) begin
      for (int j = 0; j < NC; j++) begin
        pp_r[j] <= pp_nxt[j];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < NC; j++) begin
      acc = acc + (SW'(pp_r[j]) <<< (j * AW));
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      p_r <= $signed(acc[AW+BW-1:0]);
    end
  end

  assign p = p_r;

endmodule

### hw/rtl/geometric_predicate_unit.sv
// Geometric predicate unit: exact sign of orientation, order and incircle tests.
// Nine register stages lie between the input transfer and the output register.
// Throughput one item per cycle while the output is not stalled. A stage loads
// whenever it is empty or its content moves on, so only a stalled output holds
// items back; the input stalls once every stage is full and the output stalls.
// Synchronous active-low reset clears the stage valid bits; payload is not reset.
module geometric_predicate_unit import gpu_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_command,
  input  logic signed [FIELD_W-1:0] in_ax,
  input  logic signed [FIELD_W-1:0] in_ay,
  input  logic signed [FIELD_W-1:0] in_bx,
  input  logic signed [FIELD_W-1:0] in_by,
  input  logic signed [FIELD_W-1:0] in_cx,
  input  logic signed [FIELD_W-1:0] in_cy,
  input  logic signed [FIELD_W-1:0] in_px,
  input  logic signed [FIELD_W-1:0] in_py,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [1:0]         out_sign_result
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int SUMW = 2 * W + 3;
  localparam int PW   = DW + SUMW;
  localparam int UW   = 3 * W + 6;
  localparam int QW   = DW + UW;
  localparam int DETW = 4 * W + 8;

  logic [NSTG:1] vld_r;
  logic [NSTG:1] go;

  front_en_t front_en;
  mul_en_t   mul1_en, mul2_en;

  logic signed [DW-1:0]   s3_a1, s3_a2, s3_b1, s3_b2, s3_c1, s3_c2;
  logic signed [SUMW-1:0] s3_a3, s3_b3, s3_c3, s3_cr;
  logic signed [1:0]      s3_es;
  logic                   s3_inc;

  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [DW-1:0] s4_a1_r, s4_a2_r, s5_a1_r, s5_a2_r, s6_a1_r, s6_a2_r;
  logic signed [UW-1:0] u_nxt, v_nxt, u_r, v_r;
  logic signed [QW-1:0] q1, q2;

  logic signed [1:0] es_r [4:8];
  logic [8:4]        inc_r;

  logic signed [DETW-1:0] det;
  logic signed [1:0]      sign_nxt, sign_r;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    go[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (go[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_stall = !go[1];
  assign front_en = '{s1: go[1], s2: go[2], s3: go[3]};
  assign mul1_en  = '{pp: go[4], sum: go[5]};
  assign mul2_en  = '{pp: go[7], sum: go[8]};

  gpu_front #(.CW(W)) u_front (
    .clk          (clk),
    .en           (front_en),
    .command      (in_command),
    .ax           (in_ax),
    .ay           (in_ay),
    .bx           (in_bx),
    .by           (in_by),
    .cx           (in_cx),
    .cy           (in_cy),
    .px           (in_px),
    .py           (in_py),
    .a1_o         (s3_a1),
    .a2_o         (s3_a2),
    .b1_o         (s3_b1),
    .b2_o         (s3_b2),
    .c1_o         (s3_c1),
    .c2_o         (s3_c2),
    .a3_o         (s3_a3),
    .b3_o         (s3_b3),
    .c3_o         (s3_c3),
    .cr_o         (s3_cr),
    .early_sign_o (s3_es),
    .inc_o        (s3_inc)
  );

  // det = a1*(b2*c3 - b3*c2 + a1*cr) - a2*(b1*c3 - b3*c1 - a2*cr)
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p1 (.clk(clk), .en(mul1_en), .a(s3_b2), .b(s3_c3), .p(p1));
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p2 (.clk(clk), .en(mul1_en), .a(s3_c2), .b(s3_b3), .p(p2));
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p3 (.clk(clk), .en(mul1_en), .a(s3_b1), .b(s3_c3), .p(p3));
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p4 (.clk(clk), .en(mul1_en), .a(s3_c1), .b(s3_b3), .p(p4));
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p5 (.clk(clk), .en(mul1_en), .a(s3_a1), .b(s3_cr), .p(p5));
  gpu_mul #(.AW(DW), .BW(SUMW)) u_mul_p6 (.clk(clk), .en(mul1_en), .a(s3_a2), .b(s3_cr), .p(p6));

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s4_a1_r <= s3_a1;
      s4_a2_r <= s3_a2;
      es_r[4] <= s3_es;
      inc_r[4] <= s3_inc;
    end
    for (int k = 5; k <= 8; k++) begin
      if (go[k]) begin
        es_r[k]  <= es_r[k-1];
        inc_r[k] <= inc_r[k-1];
      end
    end
    if (go[5]) begin
      s5_a1_r <= s4_a1_r;
      s5_a2_r <= s4_a2_r;
    end
  end

  assign u_nxt = UW'(p1) - UW'(p2) + UW'(p5);
  assign v_nxt = UW'(p3) - UW'(p4) - UW'(p6);

  always_ff @(posedge clk) begin
    if (go[6]) begin
      u_r     <= u_nxt;
      v_r     <= v_nxt;
      s6_a1_r <= s5_a1_r;
      s6_a2_r <= s5_a2_r;
    end
  end

  gpu_mul #(.AW(DW), .BW(UW)) u_mul_q1 (.clk(clk), .en(mul2_en), .a(s6_a1_r), .b(u_r), .p(q1));
  gpu_mul #(.AW(DW), .BW(UW)) u_mul_q2 (.clk(clk), .en(mul2_en), .a(s6_a2_r), .b(v_r), .p(q2));

  // Final stage: incircle sign from the determinant, otherwise the early sign
  always_comb begin
    det = DETW'(q1) - DETW'(q2);
    if (inc_r[8]) begin
      sign_nxt = det[DETW-1] ? SGN_NEG : ((det != '0) ? SGN_POS : SGN_ZERO);
    end else begin
      sign_nxt = es_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (go[NSTG]) begin
      sign_r <= sign_nxt;
    end
  end

  assign out_valid       = vld_r[NSTG];
  assign out_sign_result = sign_r;

`ifndef SYNTHESIS
  // The input is held back only when every stage holds an item
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a pipeline stage is empty");

  // A sum of two squares never comes out negative
  a_lift_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> !s3_a3[SUMW-1])
    else $error("lifted coordinate negative");

  a_sign_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sign_result == SGN_NEG || out_sign_result == SGN_ZERO ||
                   out_sign_result == SGN_POS))
    else $error("result sign out of range");
`endif

endmodule

### test/tb_geometric_predicate_unit.sv
// Self-checking testbench for geometric_predicate_unit: directed and random queries.
// Predicts each exact sign in 128-bit integer arithmetic and checks results in order.
// Depends on gpu_pkg and geometric_predicate_unit only.
`timescale 1ns / 100ps

module tb_geometric_predicate_unit import gpu_pkg::*;;

  localparam int RANDOM_QUERIES = 1450;
  localparam int MAX_WAIT       = 13;

  // Coordinate slots within a query
  localparam int A_X = 0;
  localparam int A_Y = 1;
  localparam int B_X = 2;
  localparam int B_Y = 3;
  localparam int C_X = 4;
  localparam int C_Y = 5;
  localparam int P_X = 6;
  localparam int P_Y = 7;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0][15:0] pt;
  } query_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [1:0]  sign;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_command = '0;
  logic signed [FIELD_W-1:0] in_ax = '0;
  logic signed [FIELD_W-1:0] in_ay = '0;
  logic signed [FIELD_W-1:0] in_bx = '0;
  logic signed [FIELD_W-1:0] in_by = '0;
  logic signed [FIELD_W-1:0] in_cx = '0;
  logic signed [FIELD_W-1:0] in_cy = '0;
  logic signed [FIELD_W-1:0] in_px = '0;
  logic signed [FIELD_W-1:0] in_py = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [1:0]         out_sign_result;

  query_t   query_backlog[$];
  verdict_t sign_due[$];
  query_t   held_query;
  int       accepted_queries = 0;
  int       mismatches = 0;
  int       send_wait = 0;
  int       recv_wait = 0;
  bit       send_quiet = 1'b0;
  bit       recv_quiet = 1'b0;
  logic     hold_on = 1'b0;

  // Lattice points on the circle of radius 5
  int lat_x[12] = '{5, 4, 3, 0, -3, -4, -5, -4, -3, 0, 3, 4};
  int lat_y[12] = '{0, 3, 4, 5, 4, 3, 0, -3, -4, -5, -4, -3};

  geometric_predicate_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_ax           (in_ax),
    .in_ay           (in_ay),
    .in_bx           (in_bx),
    .in_by           (in_by),
    .in_cx           (in_cx),
    .in_cy           (in_cy),
    .in_px           (in_px),
    .in_py           (in_py),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sign_result (out_sign_result)
  );

  always #5 clk = ~clk;

  function automatic logic signed [127:0] widen(input logic [15:0] f);
    return {{112{f[15]}}, f};
  endfunction

  function automatic logic signed [1:0] exact_sign(input query_t q);
    logic signed [127:0] ax, ay, bx, by, cx, cy, px, py, v;
    logic signed [127:0] a1, a2, b1, b2, c1, c2, a3, b3, c3;
    ax = widen(q.pt[A_X]);
    ay = widen(q.pt[A_Y]);
    bx = widen(q.pt[B_X]);
    by = widen(q.pt[B_Y]);
    cx = widen(q.pt[C_X]);
    cy = widen(q.pt[C_Y]);
    px = widen(q.pt[P_X]);
    py = widen(q.pt[P_Y]);
    case (q.cmd)
      CMD_XSIGN:     v = ax;
      CMD_YSIGN:     v = ay;
      CMD_XORDER:    v = bx - ax;
      CMD_YORDER:    v = by - ay;
      CMD_NORMORDER: v = (bx * bx + by * by) - (ax * ax + ay * ay);
      CMD_CCW:       v = ax * by - ay * bx;
      CMD_LEFTTURN:  v = (cx - bx) * (ay - by) - (cy - by) * (ax - bx);
      default: begin
        a1 = ax - px;
        a2 = ay - py;
        b1 = bx - px;
        b2 = by - py;
        c1 = cx - px;
        c2 = cy - py;
        a3 = a1 * a1 + a2 * a2;
        b3 = b1 * b1 + b2 * b2;
        c3 = c1 * c1 + c2 * c2;
        v = a1 * (b2 * c3 - b3 * c2) - a2 * (b1 * c3 - b3 * c1) + a3 * (b1 * c2 - b2 * c1);
      end
    endcase
    if (v < 0) return SGN_NEG;
    else if (v == 0) return SGN_ZERO;
    else return SGN_POS;
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic queue_query(input cmd_t c, input int ax, input int ay, input int bx,
                             input int by, input int cx, input int cy, input int px,
                             input int py);
    query_t q;
    q.cmd = c;
    q.pt[A_X] = 16'(ax);
    q.pt[A_Y] = 16'(ay);
    q.pt[B_X] = 16'(bx);
    q.pt[B_Y] = 16'(by);
    q.pt[C_X] = 16'(cx);
    q.pt[C_Y] = 16'(cy);
    q.pt[P_X] = 16'(px);
    q.pt[P_Y] = 16'(py);
    query_backlog.push_back(q);
  endtask

  function automatic int corner_value();
    case ($urandom_range(0, 5))
      0: return 'h8000;
      1: return 'h7FFF;
      2: return 0;
      3: return 'hFFFF;
      4: return 1;
      default: return 'h8001;
    endcase
  endfunction

  task automatic queue_random_query();
    query_t q;
    cmd_t   c;
    int     v[8];
    int     ox, oy, dx, dy, k, idx, m, t;
    c = cmd_t'($urandom_range(0, 7));
    for (int n = 0; n < 8; n++) v[n] = int'($urandom);
    case ($urandom_range(0, 9))
      3: for (int n = 0; n < 8; n++) v[n] = int'($urandom_range(0, 8)) - 4;
      4: for (int n = 0; n < 8; n++) v[n] = corner_value();
      5, 6: begin
        // collinear a, b, c along one direction, now and then nudged off the line
        c  = ($urandom_range(0, 1) != 0) ? CMD_CCW : CMD_LEFTTURN;
        ox = (c == CMD_CCW) ? 0 : int'($urandom_range(0, 40000)) - 20000;
        oy = (c == CMD_CCW) ? 0 : int'($urandom_range(0, 40000)) - 20000;
        dx = int'($urandom_range(0, 2000)) - 1000;
        dy = int'($urandom_range(0, 2000)) - 1000;
        for (m = 0; m < 3; m++) begin
          k = int'($urandom_range(0, 6)) - 3;
          v[2*m]   = ox + k * dx;
          v[2*m+1] = oy + k * dy;
        end
        if ($urandom_range(0, 3) == 0) v[$urandom_range(0, 5)] += 1;
      end
      7, 8: begin
        // points on one circle; around the origin for the norm comparison
        c  = ($urandom_range(0, 3) != 0) ? CMD_INCIRCLE : CMD_NORMORDER;
        ox = (c == CMD_NORMORDER) ? 0 : int'($urandom_range(0, 20000)) - 10000;
        oy = (c == CMD_NORMORDER) ? 0 : int'($urandom_range(0, 20000)) - 10000;
        k  = ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(1, 2000);
        for (m = 0; m < 4; m++) begin
          idx = $urandom_range(0, 11);
          v[2*m]   = ox + k * lat_x[idx];
          v[2*m+1] = oy + k * lat_y[idx];
        end
        if ($urandom_range(0, 3) == 0) v[$urandom_range(0, 7)] -= 1;
      end
      9: begin
        t = $urandom_range(1, 3);
        v[2*t]   = v[A_X];
        v[2*t+1] = v[A_Y];
      end
      default: ;
    endcase
    q.cmd = c;
    for (int n = 0; n < 8; n++) q.pt[n] = 16'(v[n]);
    query_backlog.push_back(q);
  endtask

  // Sender: present the next query once the current one has transferred
  always @(posedge clk) begin : drive_proc
    query_t nxt;
    verdict_t due;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due.cmd  = held_query.cmd;
        due.sign = exact_sign(held_query);
        sign_due.push_back(due);
        accepted_queries++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (query_backlog.size() != 0) begin
          nxt = query_backlog.pop_front();
          held_query <= nxt;
          in_command <= nxt.cmd;
          in_ax <= nxt.pt[A_X];
          in_ay <= nxt.pt[A_Y];
          in_bx <= nxt.pt[B_X];
          in_by <= nxt.pt[B_Y];
          in_cx <= nxt.pt[C_X];
          in_cy <= nxt.pt[C_Y];
          in_px <= nxt.pt[P_X];
          in_py <= nxt.pt[P_Y];
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
          send_wait = draw_wait(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction, then stall at random
  always @(posedge clk) begin : check_proc
    verdict_t due;
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      w = recv_wait;
      if (out_valid && !out_stall) begin
        if (sign_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_sign_result);
        end else begin
          due = sign_due.pop_front();
          if (out_sign_result !== due.sign) begin
            mismatches++;
            $display("%0t: %s sign mismatch, expected %0d, actual %0d", $time,
                     due.cmd.name(), due.sign, out_sign_result);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
        w = draw_wait(recv_quiet);
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (w > 0) begin
        out_stall <= 1'b1;
        w--;
      end else begin
        out_stall <= 1'b0;
      end
      recv_wait = w;
    end
  end

  // Long receiver hold-offs so that the pipeline fills and stalls its input
  initial begin
    for (int h = 1; h <= 2; h++) begin
      while (accepted_queries < h * 400) @(posedge clk);
      hold_on <= 1'b1;
      repeat (150) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("tb_geometric_predicate_unit: errors");
    $finish;
  end

  initial begin
    // field extremes for the single-coordinate and difference tests
    queue_query(CMD_XSIGN, -32768, 5, 1, 2, 3, 4, 6, 7);
    queue_query(CMD_XSIGN, 0, -32768, 32767, 0, 0, 0, 0, 0);
    queue_query(CMD_XSIGN, 32767, 0, -1, -1, -1, -1, -1, -1);
    queue_query(CMD_YSIGN, 32767, -32768, 0, 0, 0, 0, 0, 0);
    queue_query(CMD_YSIGN, -32768, 0, 9, 9, 9, 9, 9, 9);
    queue_query(CMD_YSIGN, 0, 32767, 0, 0, 0, 0, 0, 0);
    queue_query(CMD_XORDER, 32767, 0, -32768, 0, 0, 0, 0, 0);
    queue_query(CMD_XORDER, -32768, 0, 32767, 0, 0, 0, 0, 0);
    queue_query(CMD_XORDER, -5, 3, -5, 8, 0, 0, 0, 0);
    queue_query(CMD_YORDER, 0, 32767, 0, -32768, 0, 0, 0, 0);
    queue_query(CMD_YORDER, 0, -32768, 0, 32767, 0, 0, 0, 0);
    queue_query(CMD_YORDER, 7, -1, 2, -1, 0, 0, 0, 0);
    // norms: largest magnitudes both ways, equal norms give zero
    queue_query(CMD_NORMORDER, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
    queue_query(CMD_NORMORDER, 32767, 32767, -32768, -32768, 0, 0, 0, 0);
    queue_query(CMD_NORMORDER, 3, 4, 5, 0, 0, 0, 0, 0);
    // orientation: extremes, collinear and a plain left turn
    queue_query(CMD_CCW, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
    queue_query(CMD_CCW, 2, 4, 1, 2, 0, 0, 0, 0);
    queue_query(CMD_CCW, 1, 0, 0, 1, 0, 0, 0, 0);
    queue_query(CMD_LEFTTURN, 0, 0, 1, 0, 1, 1, 0, 0);
    queue_query(CMD_LEFTTURN, -32768, -32768, 32767, 32767, -32768, 32767, 0, 0);
    queue_query(CMD_LEFTTURN, 10, 20, 3, 4, 3, 4, 0, 0);
    // incircle: cocircular squares, inside, outside, all points equal
    queue_query(CMD_INCIRCLE, 0, 0, 1, 0, 1, 1, 0, 1);
    queue_query(CMD_INCIRCLE, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768);
    queue_query(CMD_INCIRCLE, 1, 0, 0, 1, -1, 0, 0, 0);
    queue_query(CMD_INCIRCLE, 1, 0, 0, 1, -1, 0, 5, 5);
    queue_query(CMD_INCIRCLE, -7, 3, -7, 3, -7, 3, -7, 3);
    for (int n = 0; n < RANDOM_QUERIES; n++) queue_random_query();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (query_backlog.size() != 0 || in_valid || sign_due.size() != 0);
    repeat (3 * NSTG) @(posedge clk);
    if (mismatches == 0) $display("tb_geometric_predicate_unit: clean");
    else $display("tb_geometric_predicate_unit: errors");
    $finish;
  end

endmodule
